// ===== rtl/core/tilt_steering_controller_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Tilt steering controller - assertion macros
// Shared property shorthands for the checker files.
// ----------------------------------------------------------------------------
`ifndef TILT_STEERING_CONTROLLER_UNIT_DEFINES_SVH
`define TILT_STEERING_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication
`define TSC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsc check failed");

// next-cycle implication
`define TSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsc check failed");

`endif

// ===== rtl/core/tsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Tilt steering controller - package
// Shared constants, types and the arctangent table.
// ----------------------------------------------------------------------------
package tsc_pkg;

   localparam int ANGLE_BITS_DEFAULT = 16;
   localparam int CORDIC_DEPTH       = 24;
   localparam int ITER_W             = 5;   // indexes the 24-entry table
   localparam int CSR_IDX_W          = 3;
   localparam int CSR_DATA_W         = 16;
   localparam int SPEED_W            = 11;
   localparam int SPEED_CEIL         = 1000;
   localparam int TURN_SPAN          = 500;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_START_ACCEL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEEP_ACCEL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FWD_ENTER   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FWD_KEEP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OBSTACLE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_SPEED  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TOP_SPEED   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_FWD_GAIN    = 3'd7;

   // light modes
   localparam logic [1:0] LIGHT_MOVING  = 2'd0;
   localparam logic [1:0] LIGHT_STOPPED = 2'd1;
   localparam logic [1:0] LIGHT_LEFT    = 2'd2;
   localparam logic [1:0] LIGHT_RIGHT   = 2'd3;

   typedef struct packed {
      logic [14:0] start_accel;
      logic [14:0] keep_accel;
      logic [15:0] fwd_enter;
      logic [15:0] fwd_keep;
      logic [12:0] obstacle;
      logic [9:0]  base_speed;
      logic [9:0]  top_speed;
      logic [9:0]  fwd_gain;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      start_accel: 15'd384,
      keep_accel:  15'd154,
      fwd_enter:   16'd27307,
      fwd_keep:    16'd21845,
      obstacle:    13'd80,
      base_speed:  10'd200,
      top_speed:   10'd1000,
      fwd_gain:    10'd200
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_ANGLE,
      ST_SCALE,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic              load;
      logic              step;
      logic              angle;
      logic              scale;
      logic              commit;
      logic [ITER_W-1:0] iter;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
   } status_type;

   // atan(2^-i) in 2^32-per-turn units
   function automatic logic [29:0] arctan_rev32(input logic [ITER_W-1:0] idx);
      logic [29:0] v;
      unique case (idx)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10679838;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         5'd20: v = 30'd652;
         5'd21: v = 30'd326;
         5'd22: v = 30'd163;
         5'd23: v = 30'd81;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/tsc_req_if.sv =====
// ----------------------------------------------------------------------------
// Tilt steering controller - request channel
// Valid/ready channel carrying one tilt sample and range reading per beat.
// ----------------------------------------------------------------------------
interface tsc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] tilt_x;
   logic signed [15:0] tilt_y;
   logic [12:0]        range_mm;

   modport source (output valid, tilt_x, tilt_y, range_mm, input ready);
   modport sink   (input valid, tilt_x, tilt_y, range_mm, output ready);
endinterface

// ===== rtl/core/tsc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Tilt steering controller - response channel
// Valid/ready channel carrying one wheel command per beat.
// ----------------------------------------------------------------------------
interface tsc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [10:0] left_speed;
   logic signed [10:0] right_speed;
   logic [1:0]         light_mode;
   logic               start_hold;

   modport source (output valid, left_speed, right_speed, light_mode, start_hold,
                   input ready);
   modport sink   (input valid, left_speed, right_speed, light_mode, start_hold,
                   output ready);
endinterface

// ===== rtl/core/tsc_csr.sv =====
// ----------------------------------------------------------------------------
// Tilt steering controller - configuration registers
// Write-only register bank, each write keeps the register's width.
// ----------------------------------------------------------------------------
module tsc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tsc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output tsc_pkg::cfg_type                 cfg
);

   tsc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            tsc_pkg::REG_START_ACCEL: cfg_in.start_accel = csr_wdata[14:0];
            tsc_pkg::REG_KEEP_ACCEL:  cfg_in.keep_accel  = csr_wdata[14:0];
            tsc_pkg::REG_FWD_ENTER:   cfg_in.fwd_enter   = csr_wdata;
            tsc_pkg::REG_FWD_KEEP:    cfg_in.fwd_keep    = csr_wdata;
            tsc_pkg::REG_OBSTACLE:    cfg_in.obstacle    = csr_wdata[12:0];
            tsc_pkg::REG_BASE_SPEED:  cfg_in.base_speed  = csr_wdata[9:0];
            tsc_pkg::REG_TOP_SPEED:   cfg_in.top_speed   = csr_wdata[9:0];
            tsc_pkg::REG_FWD_GAIN:    cfg_in.fwd_gain    = csr_wdata[9:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= tsc_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/tsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Tilt steering controller - sequencer
// Steps one sample through load, CORDIC iterations, angle, scale and commit.
// ----------------------------------------------------------------------------
module tsc_ctrl #(
   parameter int ANGLE_BITS = tsc_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tsc_pkg::status_type status,
   output tsc_pkg::cmd_type    cmd
);

   localparam logic [tsc_pkg::ITER_W-1:0] ITER_LAST = tsc_pkg::ITER_W'(ANGLE_BITS - 1);

   tsc_pkg::state_type           state_ff, state_in;
   logic [tsc_pkg::ITER_W-1:0]   iter_ff, iter_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsc_pkg::ST_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      iter_in    = iter_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.iter   = iter_ff;
      unique case (state_ff)
         tsc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            iter_in   = '0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = tsc_pkg::ST_ROTATE;
            end
         end
         tsc_pkg::ST_ROTATE: begin
            cmd.step = 1'b1;
            iter_in  = iter_ff + 1'b1;
            if (iter_ff == ITER_LAST) begin
               state_in = tsc_pkg::ST_ANGLE;
            end
         end
         tsc_pkg::ST_ANGLE: begin
            cmd.angle = 1'b1;
            state_in  = tsc_pkg::ST_SCALE;
         end
         tsc_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = tsc_pkg::ST_COMMIT;
         end
         tsc_pkg::ST_COMMIT: begin
            // wait here until the output register can take the result
            if (status.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = tsc_pkg::ST_IDLE;
            end
         end
         default: state_in = tsc_pkg::ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/core/tsc_datapath.sv =====
// ----------------------------------------------------------------------------
// Tilt steering controller - datapath
// CORDIC vectoring unit, speed arithmetic, latches and output register.
// ----------------------------------------------------------------------------
module tsc_datapath #(
   parameter int ANGLE_BITS = tsc_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tsc_pkg::cfg_type     cfg,
   input  tsc_pkg::cmd_type     cmd,
   output tsc_pkg::status_type  status,
   input  logic signed [15:0]   req_tilt_x,
   input  logic signed [15:0]   req_tilt_y,
   input  logic [12:0]          req_range_mm,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [10:0]   rsp_left_speed,
   output logic signed [10:0]   rsp_right_speed,
   output logic [1:0]           rsp_light_mode,
   output logic                 rsp_start_hold
);

   localparam int CW    = 20;                  // CORDIC x/y width
   localparam int ZW    = 34;                  // angle accumulator width
   localparam int SHIFT = 32 - ANGLE_BITS;
   localparam int TW    = 16 + ANGLE_BITS;
   localparam int PW    = ANGLE_BITS + 9;      // turn product width
   localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1073741824);
   localparam logic signed [ZW-1:0] ROUND   = ZW'(64'sd1 <<< (SHIFT - 1));
   localparam logic signed [ZW-1:0] HALF_Z  = ZW'(64'sd1 <<< (ANGLE_BITS - 1));
   localparam logic [ANGLE_BITS-1:0] HALF_A = ANGLE_BITS'(64'd1 << (ANGLE_BITS - 1));
   localparam logic [8:0] SPAN    = 9'(tsc_pkg::TURN_SPAN);
   localparam logic [10:0] CEIL   = 11'(tsc_pkg::SPEED_CEIL);

   // sample and iteration state
   logic [12:0]                range_ff;
   logic [15:0]                ay_ff;
   logic                       active_ff, zero_ff;
   logic signed [CW-1:0]       cx_ff, cy_ff;
   logic signed [ZW-1:0]       z_ff;
   logic                       ang_neg_ff;
   logic [ANGLE_BITS-1:0]      mag_ff;
   logic                       fwd_ff;
   logic [PW-1:0]              turn_prod_ff;
   logic [25:0]                fwd_prod_ff;

   // latches and output
   logic moving_ff, moving_in, forward_ff, forward_in, fresh_ff, fresh_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [10:0] left_ff, right_ff, left_in, right_in;
   logic [1:0]         light_ff, light_in;
   logic               hold_ff, hold_in;

   // ---- load ----
   logic [15:0]          ax_w, ay_w;
   logic [14:0]          acc_thr_w;
   logic signed [CW-1:0] xs_w, ys_w, cx0_w, cy0_w;
   logic signed [ZW-1:0] z0_w;

   always_comb begin
      ax_w      = req_tilt_x[15] ? 16'(-req_tilt_x) : 16'(req_tilt_x);
      ay_w      = req_tilt_y[15] ? 16'(-req_tilt_y) : 16'(req_tilt_y);
      acc_thr_w = moving_ff ? cfg.keep_accel : cfg.start_accel;
      xs_w      = CW'(req_tilt_x);
      ys_w      = CW'(req_tilt_y);
      cx0_w     = ys_w;
      cy0_w     = xs_w;
      z0_w      = '0;
      // pre-rotate by a quarter turn when the vector points backward
      if (req_tilt_y[15]) begin
         if (!req_tilt_x[15]) begin
            cx0_w = xs_w;
            cy0_w = -ys_w;
            z0_w  = QUARTER;
         end else begin
            cx0_w = -xs_w;
            cy0_w = ys_w;
            z0_w  = -QUARTER;
         end
      end
   end

   // ---- one CORDIC step ----
   logic signed [CW-1:0] dx_w, dy_w;
   logic signed [ZW-1:0] atan_w;

   always_comb begin
      dx_w   = cy_ff >>> cmd.iter;
      dy_w   = cx_ff >>> cmd.iter;
      atan_w = $signed({4'b0000, tsc_pkg::arctan_rev32(cmd.iter)});
   end

   // ---- angle rounding ----
   logic signed [ZW-1:0] zr_w, a_w, ac_w, aabs_w;

   always_comb begin
      zr_w = z_ff + ROUND;
      a_w  = zr_w >>> SHIFT;
      priority if (zero_ff)     ac_w = '0;
      else if (a_w > HALF_Z)    ac_w = HALF_Z;
      else if (a_w < -HALF_Z)   ac_w = -HALF_Z;
      else                      ac_w = a_w;
      aabs_w = ac_w[ZW-1] ? -ac_w : ac_w;
   end

   // ---- scale ----
   logic [TW-1:0]         thr_wide_w;
   logic [ANGLE_BITS-1:0] thr_w;

   always_comb begin
      thr_wide_w = TW'(forward_ff ? cfg.fwd_keep : cfg.fwd_enter) << ANGLE_BITS;
      thr_w      = thr_wide_w[TW-1:16];
   end

   // ---- commit ----
   logic [10:0] turn_raw_w, turn_w, fwd_sp_w;
   logic [17:0] fwd_raw_w;
   logic [9:0]  fwd_lim_w;

   always_comb begin
      turn_raw_w = 11'(cfg.base_speed) + 11'(turn_prod_ff >> (ANGLE_BITS - 1));
      turn_w     = (turn_raw_w > CEIL) ? CEIL : turn_raw_w;
      fwd_raw_w  = fwd_prod_ff[25:8];
      fwd_lim_w  = (fwd_raw_w > 18'(cfg.top_speed)) ? cfg.top_speed : fwd_raw_w[9:0];
      fwd_sp_w   = (11'(fwd_lim_w) > CEIL) ? CEIL : 11'(fwd_lim_w);

      moving_in  = moving_ff;
      forward_in = forward_ff;
      fresh_in   = fresh_ff;
      left_in    = '0;
      right_in   = '0;
      light_in   = tsc_pkg::LIGHT_STOPPED;
      hold_in    = 1'b0;
      if (active_ff) begin
         moving_in = 1'b1;
         if (fwd_ff) begin
            forward_in = 1'b1;
            if (range_ff > cfg.obstacle) begin
               left_in  = $signed(fwd_sp_w);
               right_in = $signed(fwd_sp_w);
               light_in = tsc_pkg::LIGHT_MOVING;
               hold_in  = fresh_ff;
               fresh_in = 1'b0;
            end else begin
               fresh_in = 1'b1;      // obstacle ahead: stop, keep forward latch
            end
         end else begin
            forward_in = 1'b0;
            fresh_in   = 1'b1;
            if (!ang_neg_ff) begin
               left_in  = -$signed(turn_w);
               right_in = $signed(turn_w);
               light_in = tsc_pkg::LIGHT_LEFT;
            end else begin
               left_in  = $signed(turn_w);
               right_in = -$signed(turn_w);
               light_in = tsc_pkg::LIGHT_RIGHT;
            end
         end
      end else begin
         moving_in = 1'b0;
         fresh_in  = 1'b1;
      end

      status.slot_free = !rsp_valid_ff || rsp_ready;
      if (cmd.commit)     rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         moving_ff    <= 1'b0;
         forward_ff   <= 1'b0;
         fresh_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            moving_ff  <= moving_in;
            forward_ff <= forward_in;
            fresh_ff   <= fresh_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         range_ff  <= req_range_mm;
         ay_ff     <= ay_w;
         active_ff <= (ax_w > 16'(acc_thr_w)) || (ay_w > 16'(acc_thr_w));
         zero_ff   <= (req_tilt_x == 16'sd0) && (req_tilt_y == 16'sd0);
         cx_ff     <= cx0_w;
         cy_ff     <= cy0_w;
         z_ff      <= z0_w;
      end
      if (cmd.step) begin
         if (!cy_ff[CW-1]) begin
            cx_ff <= cx_ff + dx_w;
            cy_ff <= cy_ff - dy_w;
            z_ff  <= z_ff + atan_w;
         end else begin
            cx_ff <= cx_ff - dx_w;
            cy_ff <= cy_ff + dy_w;
            z_ff  <= z_ff - atan_w;
         end
      end
      if (cmd.angle) begin
         ang_neg_ff <= ac_w[ZW-1];
         mag_ff     <= aabs_w[ANGLE_BITS-1:0];
      end
      if (cmd.scale) begin
         fwd_ff       <= mag_ff > thr_w;
         turn_prod_ff <= PW'(HALF_A - mag_ff) * PW'(SPAN);
         fwd_prod_ff  <= 26'(cfg.fwd_gain) * 26'(ay_ff);
      end
      if (cmd.commit) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         light_ff <= light_in;
         hold_ff  <= hold_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_speed  = left_ff;
   assign rsp_right_speed = right_ff;
   assign rsp_light_mode  = light_ff;
   assign rsp_start_hold  = hold_ff;

endmodule

// ===== rtl/core/tilt_steering_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Tilt steering controller unit - top level
// Turns a two-axis tilt sample and a range reading into wheel commands.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                       handshake
//  req_chan  in   tilt_x, tilt_y, range_mm                      valid/ready
//  rsp_chan  out  left_speed, right_speed, light_mode, hold     valid/ready
//  csr_*     in   csr_index, csr_wdata                          csr_we strobe
//
//  One sample at a time: a load step, ANGLE_BITS CORDIC iterations (one per
//  cycle on a single shift/add unit), then the angle, scale and commit steps.
//  The result sits in an output register; the next sample is taken as soon as
//  it lands there, while the previous beat may still wait for rsp ready.
//  A stalled response holds the sequencer in commit until the slot frees.
//  Reset is synchronous, active high; control and configuration registers
//  return to their defaults, the sample and payload registers are not reset.
// ----------------------------------------------------------------------------
module tilt_steering_controller_unit #(
   parameter int ANGLE_BITS = tsc_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   tsc_req_if.sink                         req_chan,
   tsc_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [tsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tsc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   tsc_pkg::cfg_type    cfg;
   tsc_pkg::cmd_type    cmd;
   tsc_pkg::status_type status;

   // register bank
   tsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: ready only while idle
   tsc_ctrl #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // CORDIC, speed math, steering latches, output register
   tsc_datapath #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .req_tilt_x      (req_chan.tilt_x),
      .req_tilt_y      (req_chan.tilt_y),
      .req_range_mm    (req_chan.range_mm),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_left_speed  (rsp_chan.left_speed),
      .rsp_right_speed (rsp_chan.right_speed),
      .rsp_light_mode  (rsp_chan.light_mode),
      .rsp_start_hold  (rsp_chan.start_hold)
   );

endmodule

// ===== rtl/core/tsc_checker.sv =====
// ----------------------------------------------------------------------------
// Tilt steering controller - port checker
// Watches the response channel and checks the wheel command shapes.
// ----------------------------------------------------------------------------
`include "tilt_steering_controller_unit_defines.svh"

module tsc_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [10:0] left_speed,
   input logic signed [10:0] right_speed,
   input logic [1:0]         light_mode,
   input logic               start_hold
);

   logic [24:0] payload;
   logic        stalled, fwd_shape, stopped, wheels_idle, spin, spin_sym;

   assign payload     = {left_speed, right_speed, light_mode, start_hold};
   assign stalled     = rsp_valid && !rsp_ready;
   assign fwd_shape   = (light_mode == tsc_pkg::LIGHT_MOVING) && (left_speed == right_speed);
   assign stopped     = rsp_valid && (light_mode == tsc_pkg::LIGHT_STOPPED);
   assign wheels_idle = (left_speed == 11'sd0) && (right_speed == 11'sd0);
   assign spin        = rsp_valid && ((light_mode == tsc_pkg::LIGHT_LEFT) ||
                                      (light_mode == tsc_pkg::LIGHT_RIGHT));
   assign spin_sym    = 11'(left_speed + right_speed) == 11'd0;

   // a stalled beat stays up
   `TSC_ASSERT_NEXT(a_valid_hold, clock, reset, stalled, rsp_valid)

   // a stalled beat keeps its payload
   `TSC_ASSERT_NEXT(a_payload_hold, clock, reset, stalled, $stable(payload))

   // start hold only on forward drive, both wheels equal
   `TSC_ASSERT_IMPLY(a_hold_fwd, clock, reset, rsp_valid && start_hold, fwd_shape)

   // stopped means both wheels at zero
   `TSC_ASSERT_IMPLY(a_stop_zero, clock, reset, stopped, wheels_idle)

   // spins drive the wheels in opposite directions
   `TSC_ASSERT_IMPLY(a_spin_sym, clock, reset, spin, spin_sym)

endmodule

bind tilt_steering_controller_unit tsc_checker u_tsc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .left_speed  (rsp_chan.left_speed),
   .right_speed (rsp_chan.right_speed),
   .light_mode  (rsp_chan.light_mode),
   .start_hold  (rsp_chan.start_hold)
);
